// ===== src/deq_pkg.sv =====
// deq_pkg: shared types, codes and defaults for the double-ended queue
// no dependencies; used by every module of the block but deq_ram
`timescale 1ns / 1ps
`default_nettype none

package deq_pkg;

	// default ring depth, element width and code widths
	localparam int DEPTH_DEF = 16;
	localparam int DATA_W    = 32;
	localparam int CMD_W     = 3;
	localparam int STATUS_W  = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_POP_BACK   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DUMP       = 3'd4;

	// result status codes
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

	// input item
	typedef struct packed {
		logic [CMD_W-1:0]         command;
		logic signed [DATA_W-1:0] value;
	} in_item_t;

	// result item
	typedef struct packed {
		logic [STATUS_W-1:0]      status;
		logic signed [DATA_W-1:0] value_res;
		logic                     last;
	} out_item_t;

	// controller to datapath commands
	typedef struct packed {
		logic                wr_front;
		logic                wr_back;
		logic                rd_front;
		logic                rd_back;
		logic                rd_first;
		logic                rd_next;
		logic                ld_imm;
		logic                ld_mem;
		logic                mem_last;
		logic [STATUS_W-1:0] imm_status;
	} dp_cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic empty;
		logic full;
		logic dump_last;
	} dp_sts_t;

endpackage

`default_nettype wire

// ===== src/deq_ram.sv =====
// deq_ram: generic single write port, single read port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module deq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== src/deq_ctrl.sv =====
// deq_ctrl: command sequencer of the double-ended queue
// depends on deq_pkg for codes and the command/status structs
`timescale 1ns / 1ps
`default_nettype none

module deq_ctrl (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output      logic                       in_ready,
	input  wire logic [deq_pkg::CMD_W-1:0]  command,
	output      logic                       out_valid,
	input  wire logic                       out_ready,
	input  wire deq_pkg::dp_sts_t           sts,
	output      deq_pkg::dp_cmd_t           cmd
);

	// state codes
	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_RD   = 2'd1;
	localparam logic [1:0] S_OUT  = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       dump_q;
	logic       dump_d;

	// next state and datapath commands
	always_comb begin
		state_d   = state_q;
		dump_d    = dump_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					dump_d = 1'b0;
					case (command)
						deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
							cmd.ld_imm = 1'b1;
							if (sts.full) begin
								cmd.imm_status = deq_pkg::ST_FULL;
							end else begin
								cmd.imm_status = deq_pkg::ST_OK;
								cmd.wr_front   = (command == deq_pkg::CMD_PUSH_FRONT);
								cmd.wr_back    = (command == deq_pkg::CMD_PUSH_BACK);
							end
							state_d = S_OUT;
						end
						deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
							if (sts.empty) begin
								cmd.ld_imm     = 1'b1;
								cmd.imm_status = deq_pkg::ST_EMPTY;
								state_d        = S_OUT;
							end else begin
								cmd.rd_front = (command == deq_pkg::CMD_POP_FRONT);
								cmd.rd_back  = (command == deq_pkg::CMD_POP_BACK);
								state_d      = S_RD;
							end
						end
						deq_pkg::CMD_DUMP: begin
							if (sts.empty) begin
								cmd.ld_imm     = 1'b1;
								cmd.imm_status = deq_pkg::ST_EMPTY;
								state_d        = S_OUT;
							end else begin
								cmd.rd_first = 1'b1;
								dump_d       = 1'b1;
								state_d      = S_RD;
							end
						end
						default: begin
							// unknown codes are dropped without a result
							state_d = S_IDLE;
						end
					endcase
				end
			end
			S_RD: begin
				// ram data is ready, capture it into the result register
				cmd.ld_mem   = 1'b1;
				cmd.mem_last = !dump_q || sts.dump_last;
				state_d      = S_OUT;
			end
			S_OUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (dump_q && !sts.dump_last) begin
						cmd.rd_next = 1'b1;
						state_d     = S_RD;
					end else begin
						state_d = S_IDLE;
					end
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			dump_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			dump_q  <= dump_d;
		end
	end

endmodule

`default_nettype wire

// ===== src/deq_dp.sv =====
// deq_dp: ring pointers, element store and result register of the queue
// depends on deq_pkg and deq_ram
`timescale 1ns / 1ps
`default_nettype none

module deq_dp #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic signed [deq_pkg::DATA_W-1:0] value,
	input  wire deq_pkg::dp_cmd_t                 cmd,
	output      deq_pkg::dp_sts_t                 sts,
	output      deq_pkg::out_item_t               res
);

	localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	logic [IW-1:0]              front_q;
	logic [CW-1:0]              count_q;
	logic [IW-1:0]              off_q;
	deq_pkg::out_item_t         res_q;

	logic [IW-1:0]              front_dec;
	logic [IW-1:0]              back_next;
	logic [IW-1:0]              back_last;
	logic [IW-1:0]              dump_pos;
	logic [IW-1:0]              off_inc;
	logic                       we;
	logic [IW-1:0]              waddr;
	logic                       re;
	logic [IW-1:0]              raddr;
	logic [deq_pkg::DATA_W-1:0] rdata;

	// front plus offset, wrapped once around the ring
	function automatic logic [IW-1:0] ring_pos(input logic [IW-1:0] base,
		input logic [IW-1:0] off);
		logic [IW:0] s;
		s = {1'b0, base} + {1'b0, off};
		if (s >= (IW+1)'(DEPTH)) begin
			s = s - (IW+1)'(DEPTH);
		end
		return s[IW-1:0];
	endfunction

	// ring positions
	assign front_dec = (front_q == '0) ? IW'(DEPTH - 1) : front_q - IW'(1);
	assign back_next = ring_pos(front_q, count_q[IW-1:0]);
	assign back_last = ring_pos(front_q, IW'(count_q - CW'(1)));
	assign off_inc   = off_q + IW'(1);
	assign dump_pos  = ring_pos(front_q, off_inc);

	// status to the controller
	assign sts.empty     = (count_q == '0);
	assign sts.full      = (count_q == CW'(DEPTH));
	assign sts.dump_last = ((CW'(off_q) + CW'(1)) == count_q);

	// ram port selection
	assign we    = cmd.wr_front || cmd.wr_back;
	assign waddr = cmd.wr_front ? front_dec : back_next;
	assign re    = cmd.rd_front || cmd.rd_back || cmd.rd_first || cmd.rd_next;
	always_comb begin
		if (cmd.rd_back) begin
			raddr = back_last;
		end else if (cmd.rd_next) begin
			raddr = dump_pos;
		end else begin
			raddr = front_q;
		end
	end

	deq_ram #(
		.WIDTH(deq_pkg::DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(value),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	// front index and element count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			count_q <= '0;
		end else begin
			if (cmd.wr_front) begin
				front_q <= front_dec;
				count_q <= count_q + CW'(1);
			end else if (cmd.wr_back) begin
				count_q <= count_q + CW'(1);
			end else if (cmd.rd_front) begin
				front_q <= ring_pos(front_q, IW'(1));
				count_q <= count_q - CW'(1);
			end else if (cmd.rd_back) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// dump offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			off_q <= '0;
		end else if (cmd.rd_first) begin
			off_q <= '0;
		end else if (cmd.rd_next) begin
			off_q <= off_inc;
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.ld_imm) begin
			res_q.status    <= cmd.imm_status;
			res_q.value_res <= '0;
			res_q.last      <= 1'b1;
		end else if (cmd.ld_mem) begin
			res_q.status    <= deq_pkg::ST_OK;
			res_q.value_res <= $signed(rdata);
			res_q.last      <= cmd.mem_last;
		end
	end

	assign res = res_q;

endmodule

`default_nettype wire

// ===== src/double_ended_queue.sv =====
// double_ended_queue: ring-buffer deque of signed 32-bit values, one command per item
// Push or refusal: the result register is loaded at accept and shown in the next cycle.
// Pop or first dump element: the ram is read at accept, the result loaded in S_RD and
// shown in S_OUT; each further dump element is read when the previous one is taken.
// One item at a time; a new item is taken in the cycle after the last result leaves.
// Reset clears front index, element count and control; the element store is not cleared.
// depends on deq_pkg, deq_ctrl, deq_dp
`timescale 1ns / 1ps
`default_nettype none

module double_ended_queue #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output      logic               in_ready,
	input  wire deq_pkg::in_item_t  in_data,
	output      logic               out_valid,
	input  wire logic               out_ready,
	output      deq_pkg::out_item_t out_data
);

	deq_pkg::dp_cmd_t dp_cmd;
	deq_pkg::dp_sts_t dp_sts;

	// sequencer
	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.command  (in_data.command),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sts      (dp_sts),
		.cmd      (dp_cmd)
	);

	// storage and pointers
	deq_dp #(
		.DEPTH(DEPTH)
	) u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.value (in_data.value),
		.cmd   (dp_cmd),
		.sts   (dp_sts),
		.res   (out_data)
	);

endmodule

`default_nettype wire

// ===== test/deque_checker.sv =====
// deque_checker: watches both item channels of the double-ended queue, keeps a
// shadow ring that predicts every result, and compares results as they are taken
// depends on deq_pkg only
`timescale 1ns / 1ps

module deque_checker #(
	parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire deq_pkg::in_item_t  in_data,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire deq_pkg::out_item_t out_data,
	output int                      mismatches,
	output int                      expected_left,
	output int                      results_checked,
	output int                      commands_seen,
	output int                      full_refusals,
	output int                      empty_refusals
);

	import deq_pkg::*;

	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int COUNT_W = IDX_W + 1;

	// shadow copy of the ring
	logic signed [DATA_W-1:0] shadow_ring [DEPTH];
	logic [IDX_W-1:0]         shadow_front;
	logic [COUNT_W-1:0]       shadow_count;

	// results still owed by the block, oldest first
	out_item_t awaited_results [$];

	int error_tally;
	int checked_tally;
	int command_tally;
	int full_tally;
	int empty_tally;

	// ring position a given distance after the front entry
	function automatic logic [IDX_W-1:0] ring_slot(input int offset);
		return IDX_W'((int'(shadow_front) + offset) % DEPTH);
	endfunction

	// work out the results of one command and advance the shadow ring
	function automatic void predict_deque_results(input in_item_t item);
		out_item_t        res;
		logic [IDX_W-1:0] pos;
		int               k;
		res = '0;
		res.status = ST_OK;
		res.last = 1'b1;
		case (item.command)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (int'(shadow_count) >= DEPTH) begin
					res.status = ST_FULL;
					full_tally++;
				end else begin
					if (item.command == CMD_PUSH_FRONT) begin
						shadow_front = ring_slot(DEPTH - 1);
						shadow_ring[shadow_front] = item.value;
					end else begin
						shadow_ring[ring_slot(int'(shadow_count))] = item.value;
					end
					shadow_count = shadow_count + 1'b1;
				end
				awaited_results.push_back(res);
			end
			CMD_POP_FRONT, CMD_POP_BACK: begin
				if (shadow_count == '0) begin
					res.status = ST_EMPTY;
					empty_tally++;
				end else begin
					if (item.command == CMD_POP_FRONT) begin
						pos = shadow_front;
						shadow_front = ring_slot(1);
					end else begin
						pos = ring_slot(int'(shadow_count) - 1);
					end
					shadow_count = shadow_count - 1'b1;
					res.value_res = shadow_ring[pos];
				end
				awaited_results.push_back(res);
			end
			CMD_DUMP: begin
				if (shadow_count == '0) begin
					res.status = ST_EMPTY;
					empty_tally++;
					awaited_results.push_back(res);
				end else begin
					for (k = 0; k < int'(shadow_count); k++) begin
						res.value_res = shadow_ring[ring_slot(k)];
						res.last = (k + 1 == int'(shadow_count));
						awaited_results.push_back(res);
					end
				end
			end
			default: begin
				// spare codes leave the ring alone and give nothing
			end
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		$display("[%0t] mismatch: %s", $time, what);
		error_tally++;
	endtask

	// compare taken results first, then predict from the taken command
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			shadow_front = '0;
			shadow_count = '0;
			awaited_results.delete();
			error_tally = 0;
			checked_tally = 0;
			command_tally = 0;
			full_tally = 0;
			empty_tally = 0;
		end else begin
			if (out_valid && out_ready) begin
				checked_tally++;
				if (awaited_results.size() == 0) begin
					report_mismatch($sformatf("unexpected result status %0d value %0d last %0b",
						out_data.status, out_data.value_res, out_data.last));
				end else begin
					want = awaited_results.pop_front();
					if (out_data.status !== want.status)
						report_mismatch($sformatf("status %0d, expected %0d",
							out_data.status, want.status));
					if (out_data.value_res !== want.value_res)
						report_mismatch($sformatf("value %0d, expected %0d",
							out_data.value_res, want.value_res));
					if (out_data.last !== want.last)
						report_mismatch($sformatf("last %0b, expected %0b",
							out_data.last, want.last));
				end
			end
			if (in_valid && in_ready) begin
				command_tally++;
				predict_deque_results(in_data);
			end
		end
		expected_left   <= awaited_results.size();
		mismatches      <= error_tally;
		results_checked <= checked_tally;
		commands_seen   <= command_tally;
		full_refusals   <= full_tally;
		empty_refusals  <= empty_tally;
	end

endmodule

// ===== test/double_ended_queue_test.sv =====
// double_ended_queue_test: drives commands into the deque with random gaps and
// output stalls, gives the verdict from the checker's mismatch count and results still owed
// depends on deq_pkg, double_ended_queue and deque_checker
`timescale 1ns / 1ps

module double_ended_queue_test;

	import deq_pkg::*;

	localparam int DEPTH           = DEPTH_DEF;
	localparam int RANDOM_COMMANDS = 410;
	localparam int WATCHDOG_LIMIT  = 2000;
	localparam int LONG_HOLD       = 150;
	localparam int SETTLE_CYCLES   = 20;

	// codes the block has no use for
	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

	typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} burst_mode_t;

	logic      clk;
	logic      arst_n    = 1'b0;
	logic      in_valid  = 1'b0;
	logic      in_ready;
	in_item_t  in_data   = '0;
	logic      out_valid;
	logic      out_ready = 1'b0;
	out_item_t out_data;

	int mismatches;
	int expected_left;
	int results_checked;
	int commands_seen;
	int full_refusals;
	int empty_refusals;

	bit steady_phase = 1'b0;
	int idle_cycles  = 0;

	double_ended_queue #(
		.DEPTH(DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	deque_checker #(
		.DEPTH(DEPTH)
	) checker_inst (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.mismatches(mismatches),
		.expected_left(expected_left),
		.results_checked(results_checked),
		.commands_seen(commands_seen),
		.full_refusals(full_refusals),
		.empty_refusals(empty_refusals)
	);

	// 20 ns clock
	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// offer one item after a random gap (none in a steady phase) and hold it until taken
	task automatic offer_command(input logic [CMD_W-1:0] cmd,
			input logic signed [DATA_W-1:0] val);
		in_item_t item;
		int       gap;
		item.command = cmd;
		item.value = val;
		gap = steady_phase ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= item;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
	endtask

	// element values lean on the extremes now and then
	function automatic logic signed [DATA_W-1:0] pick_value();
		case ($urandom_range(0, 7))
			0: return 32'sh7fff_ffff;
			1: return 32'sh8000_0000;
			2: return '0;
			3: return -32'sd1;
			default: return $urandom();
		endcase
	endfunction

	// command mix depends on whether the burst fills, drains or mixes
	function automatic logic [CMD_W-1:0] pick_command(input burst_mode_t mode);
		int r;
		r = $urandom_range(0, 99);
		case (mode)
			MODE_FILL: begin
				if (r < 40) return CMD_PUSH_FRONT;
				if (r < 75) return CMD_PUSH_BACK;
				if (r < 85) return CMD_POP_FRONT;
				if (r < 95) return CMD_POP_BACK;
			end
			MODE_DRAIN: begin
				if (r < 10) return CMD_PUSH_FRONT;
				if (r < 20) return CMD_PUSH_BACK;
				if (r < 55) return CMD_POP_FRONT;
				if (r < 90) return CMD_POP_BACK;
			end
			default: begin
				if (r < 22) return CMD_PUSH_FRONT;
				if (r < 44) return CMD_PUSH_BACK;
				if (r < 64) return CMD_POP_FRONT;
				if (r < 84) return CMD_POP_BACK;
			end
		endcase
		return CMD_DUMP;
	endfunction

	// command source: reset, directed cases, random bursts, then drain and verdict
	initial begin
		burst_mode_t      mode;
		int               sent;
		int               burst_len;
		int               k;
		logic [CMD_W-1:0] spare;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty ring: both pops and a dump are refused
		offer_command(CMD_POP_FRONT, 32'sd5);
		offer_command(CMD_POP_BACK, -32'sd5);
		offer_command(CMD_DUMP, '0);
		// spare codes are ignored
		for (spare = CMD_SPARE_FIRST; spare != CMD_SPARE_LAST; spare++)
			offer_command(spare, $urandom());
		offer_command(CMD_SPARE_LAST, $urandom());
		// extremes at both ends, then fill to the brim
		offer_command(CMD_PUSH_FRONT, 32'sh7fff_ffff);
		offer_command(CMD_PUSH_BACK, 32'sh8000_0000);
		for (k = 2; k < DEPTH; k++)
			offer_command((k % 2) ? CMD_PUSH_FRONT : CMD_PUSH_BACK,
				(k % 3 == 0) ? -32'sd1 : $urandom());
		// full ring: pushes refused, dump lists every entry
		offer_command(CMD_PUSH_FRONT, 32'sd1);
		offer_command(CMD_PUSH_BACK, 32'sd2);
		offer_command(CMD_DUMP, '0);
		offer_command(CMD_POP_FRONT, '0);
		offer_command(CMD_POP_BACK, '0);

		// random bursts with occasional spare codes as noise
		sent = 0;
		while (sent < RANDOM_COMMANDS) begin
			mode = burst_mode_t'($urandom_range(0, 2));
			steady_phase = ($urandom_range(0, 3) == 0);
			burst_len = $urandom_range(8, 24);
			repeat (burst_len) begin
				if ($urandom_range(0, 24) == 0) begin
					offer_command(CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST)),
						$urandom());
				end else begin
					offer_command(pick_command(mode), pick_value());
					sent++;
				end
			end
		end
		steady_phase = 1'b0;
		in_valid <= 1'b0;

		// let the last results come out
		@(posedge clk);
		while (expected_left != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run covered %0d commands and %0d results", commands_seen, results_checked);
		$display("pushes refused on a full ring: %0d, commands refused on an empty one: %0d",
			full_refusals, empty_refusals);
		if (mismatches == 0 && expected_left == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	// result sink: random stalls, plus two long hold-offs that back the block up
	initial begin
		int taken;
		int hold;
		taken = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			hold = 0;
			if (taken == 120 || taken == 380)
				hold = LONG_HOLD;
			else if (!steady_phase)
				hold = $urandom_range(0, 3);
			if (hold > 0) begin
				out_ready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid) @(posedge clk);
			taken++;
		end
	end

	// watchdog on cycles with no item moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("timeout after %0d cycles with no item moving", idle_cycles);
				$display("Verification failed");
				$finish;
			end
		end
	end

endmodule

// ===== filelist.f =====
src/deq_pkg.sv
src/deq_ram.sv
src/deq_ctrl.sv
src/deq_dp.sv
src/double_ended_queue.sv
test/deque_checker.sv
test/double_ended_queue_test.sv
